FILE: design/snvs_pkg.sv
`default_nettype none

package snvs_pkg;

  // Volume limits and sample format
  localparam int MaxWidth  = 64;
  localparam int MaxHeight = 64;
  localparam int MaxDepth  = 64;
  localparam int SampleW   = 16;

  localparam int DimW    = 7;
  localparam int XW      = $clog2(MaxWidth);
  localparam int YW      = $clog2(MaxHeight);
  localparam int ZW      = $clog2(MaxDepth);
  localparam int CfgIdxW = 2;

  // Q16 blend weight
  localparam int WeightFrac = 16;
  localparam int WeightW    = WeightFrac + 1;
  localparam int WeightOne  = 1 << WeightFrac;
  localparam int RoundHalf  = 1 << (WeightFrac - 1);
  localparam int ProdW      = WeightW + 1 + SampleW + 1;

  // Window delay lines: plane gap is w*(h-1), line gap is w-1
  localparam int PlGapMax   = MaxWidth * (MaxHeight - 1);
  localparam int PlGapW     = $clog2(PlGapMax + 1);
  localparam int PlRamDepth = PlGapMax - 1;
  localparam int LnRamDepth = MaxWidth - 2;

  // Sum of six samples plus rounding, and floor(q/3) by reciprocal
  localparam int SumW        = SampleW + 3;
  localparam int HalfSumW    = SumW - 1;
  localparam int Recip3W     = HalfSumW + 1;
  localparam int Recip3Shift = HalfSumW + 2;
  localparam logic [Recip3W-1:0] Recip3 = Recip3W'(((1 << Recip3Shift) + 2) / 3);
  localparam int Prod3W      = HalfSumW + Recip3W;

  localparam logic CmdPush  = 1'b0;
  localparam logic CmdDrain = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    RegWidth  = 2'd0,
    RegHeight = 2'd1,
    RegDepth  = 2'd2,
    RegWeight = 2'd3
  } cfg_reg_e;

  typedef logic [SampleW-1:0] sample_t;

  typedef struct packed {
    logic valid;
    logic xm;
    logic xp;
    logic ym;
    logic yp;
    logic zm;
    logic zp;
    logic last;
  } ctrl_t;

  typedef struct packed {
    sample_t zp;
    sample_t yp;
    sample_t xp;
    sample_t ctr;
    sample_t xm;
    sample_t ym;
    sample_t zm;
  } taps_t;

endpackage

`default_nettype wire

FILE: design/snvs_ram.sv
`default_nettype none

module snvs_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read-first: the old entry comes out as the new one goes in
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q        <= mem_q[addr_i];
      mem_q[addr_i]  <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/snvs_window.sv
`default_nettype none

module snvs_window (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         restart_i,
  input  wire logic [snvs_pkg::DimW-1:0]    width_i,
  input  wire logic [snvs_pkg::DimW-1:0]    height_i,
  input  wire logic [snvs_pkg::DimW-1:0]    depth_i,
  input  wire logic                         s_valid_i,
  input  wire logic                         s_cmd_i,
  input  wire snvs_pkg::sample_t            s_voxel_i,
  output logic                              s_ready_o,
  input  wire logic                         next_ready_i,
  output snvs_pkg::ctrl_t                   ctrl_o,
  output snvs_pkg::taps_t                   taps_o
);

  localparam int NumSeg = 4;

  logic [snvs_pkg::XW-1:0] wm1;
  logic [snvs_pkg::YW-1:0] hm1;
  logic [snvs_pkg::ZW-1:0] dm1;

  logic [2*snvs_pkg::DimW-1:0] gap_prod;
  logic [snvs_pkg::PlGapW-1:0] gap_pl_q;
  logic [snvs_pkg::PlGapW-1:0] gap_ln_q;
  logic                        settle_q;

  logic [snvs_pkg::XW-1:0] in_x_q, out_x_q;
  logic [snvs_pkg::YW-1:0] in_y_q, out_y_q;
  logic [snvs_pkg::ZW-1:0] in_z_q, out_z_q;
  logic                    in_full_q;

  snvs_pkg::ctrl_t ctrl_q;
  logic            en0;
  logic            accept;
  logic            do_push;
  logic            do_shift;
  logic            emit;
  logic            last_out;

  snvs_pkg::sample_t zp_q, ctr_q, xm_q;
  snvs_pkg::sample_t seg_in  [NumSeg];
  snvs_pkg::sample_t seg_out [NumSeg];
  logic [snvs_pkg::PlGapW-1:0] seg_gap [NumSeg];

  assign wm1 = snvs_pkg::XW'(width_i - snvs_pkg::DimW'(1));
  assign hm1 = snvs_pkg::YW'(height_i - snvs_pkg::DimW'(1));
  assign dm1 = snvs_pkg::ZW'(depth_i - snvs_pkg::DimW'(1));

  assign gap_prod = (2*snvs_pkg::DimW)'(width_i)
                  * (2*snvs_pkg::DimW)'(height_i - snvs_pkg::DimW'(1));

  always_ff @(posedge clk_i) begin
    gap_pl_q <= snvs_pkg::PlGapW'(gap_prod);
    gap_ln_q <= snvs_pkg::PlGapW'(wm1);
  end

  // hold off input after reset or a dimension change so the gaps settle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= 1'b1;
    end else begin
      settle_q <= restart_i;
    end
  end

  assign en0       = !ctrl_q.valid || next_ready_i;
  assign s_ready_o = en0 && !settle_q;
  assign accept    = s_valid_i && s_ready_o;
  assign do_push   = accept && (s_cmd_i == snvs_pkg::CmdPush) && !in_full_q;
  assign do_shift  = do_push || (accept && in_full_q);
  assign emit      = do_push ? (in_z_q != '0) : (accept && in_full_q);
  assign last_out  = (out_x_q == wm1) && (out_y_q == hm1) && (out_z_q == dm1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q    <= '0;
      in_x_q    <= '0;
      in_y_q    <= '0;
      in_z_q    <= '0;
      in_full_q <= 1'b0;
      out_x_q   <= '0;
      out_y_q   <= '0;
      out_z_q   <= '0;
    end else begin
      if (en0) begin
        ctrl_q.valid <= emit;
        ctrl_q.xm    <= (out_x_q != '0);
        ctrl_q.xp    <= (out_x_q != wm1);
        ctrl_q.ym    <= (out_y_q != '0);
        ctrl_q.yp    <= (out_y_q != hm1);
        ctrl_q.zm    <= (out_z_q != '0);
        ctrl_q.zp    <= (out_z_q != dm1);
        ctrl_q.last  <= last_out;
      end
      if (restart_i) begin
        in_x_q    <= '0;
        in_y_q    <= '0;
        in_z_q    <= '0;
        in_full_q <= 1'b0;
        out_x_q   <= '0;
        out_y_q   <= '0;
        out_z_q   <= '0;
      end else begin
        if (do_push) begin
          if (in_x_q == wm1) begin
            in_x_q <= '0;
            if (in_y_q == hm1) begin
              in_y_q <= '0;
              if (in_z_q == dm1) begin
                in_full_q <= 1'b1;
              end else begin
                in_z_q <= in_z_q + snvs_pkg::ZW'(1);
              end
            end else begin
              in_y_q <= in_y_q + snvs_pkg::YW'(1);
            end
          end else begin
            in_x_q <= in_x_q + snvs_pkg::XW'(1);
          end
        end
        if (emit) begin
          if (last_out) begin
            // volume done: start the next one
            in_x_q    <= '0;
            in_y_q    <= '0;
            in_z_q    <= '0;
            in_full_q <= 1'b0;
            out_x_q   <= '0;
            out_y_q   <= '0;
            out_z_q   <= '0;
          end else if (out_x_q == wm1) begin
            out_x_q <= '0;
            if (out_y_q == hm1) begin
              out_y_q <= '0;
              out_z_q <= out_z_q + snvs_pkg::ZW'(1);
            end else begin
              out_y_q <= out_y_q + snvs_pkg::YW'(1);
            end
          end else begin
            out_x_q <= out_x_q + snvs_pkg::XW'(1);
          end
        end
      end
    end
  end

  // Tap chain, newest first: zp -(plane gap)- yp -(line gap)- xp - ctr - xm
  //   -(line gap)- ym -(plane gap)- zm. Drain steps shift in don't-care samples.
  always_ff @(posedge clk_i) begin
    if (do_shift) begin
      zp_q  <= s_voxel_i;
      ctr_q <= seg_out[1];
      xm_q  <= ctr_q;
    end
  end

  assign seg_in[0] = zp_q;
  assign seg_in[1] = seg_out[0];
  assign seg_in[2] = xm_q;
  assign seg_in[3] = seg_out[2];

  assign seg_gap[0] = gap_pl_q;
  assign seg_gap[1] = gap_ln_q;
  assign seg_gap[2] = gap_ln_q;
  assign seg_gap[3] = gap_pl_q;

  for (genvar i = 0; i < NumSeg; i++) begin : g_seg
    localparam int Depth = (i == 0 || i == 3) ? snvs_pkg::PlRamDepth : snvs_pkg::LnRamDepth;
    localparam int AddrW = $clog2(Depth);

    logic [AddrW-1:0]  ptr_q;
    logic              wrap;
    snvs_pkg::sample_t hold_q;
    snvs_pkg::sample_t rd;

    // RAM holds gap-1 samples; its read register adds the last step of delay
    assign wrap = (seg_gap[i] < snvs_pkg::PlGapW'(2))
               || (snvs_pkg::PlGapW'(ptr_q) >= seg_gap[i] - snvs_pkg::PlGapW'(2));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ptr_q <= '0;
      end else if (do_shift) begin
        ptr_q <= wrap ? '0 : ptr_q + AddrW'(1);
      end
    end

    always_ff @(posedge clk_i) begin
      if (do_shift) begin
        hold_q <= seg_in[i];
      end
    end

    snvs_ram #(
      .Width (snvs_pkg::SampleW),
      .Depth (Depth)
    ) u_ram (
      .clk_i   (clk_i),
      .en_i    (do_shift),
      .addr_i  (ptr_q),
      .wdata_i (seg_in[i]),
      .rdata_o (rd)
    );

    // gap of zero passes through, gap of one is a plain register
    assign seg_out[i] = (seg_gap[i] == '0)                    ? seg_in[i] :
                        (seg_gap[i] == snvs_pkg::PlGapW'(1))  ? hold_q    : rd;
  end

  assign ctrl_o     = ctrl_q;
  assign taps_o.zp  = zp_q;
  assign taps_o.yp  = seg_out[0];
  assign taps_o.xp  = seg_out[1];
  assign taps_o.ctr = ctr_q;
  assign taps_o.xm  = xm_q;
  assign taps_o.ym  = seg_out[2];
  assign taps_o.zm  = seg_out[3];

endmodule

`default_nettype wire

FILE: design/snvs_arith.sv
`default_nettype none

module snvs_arith (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [snvs_pkg::WeightW-1:0]   weight_i,
  input  wire snvs_pkg::ctrl_t                ctrl_i,
  input  wire snvs_pkg::taps_t                taps_i,
  output logic                                ready_o,
  output logic                                m_valid_o,
  input  wire logic                           m_ready_i,
  output snvs_pkg::sample_t                   m_voxel_o,
  output logic                                m_last_o
);

  localparam int PairW = snvs_pkg::SampleW + 1;
  localparam int AdjW  = snvs_pkg::ProdW - snvs_pkg::WeightFrac;

  logic en1, en2, en3, en4, en5;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic l1_q, l2_q, l3_q, l4_q, l5_q;

  snvs_pkg::sample_t c1_q, c2_q, c3_q, c4_q;
  snvs_pkg::sample_t nxm, nxp, nym, nyp, nzm, nzp;

  logic [PairW-1:0]                  sx_q, sy_q, sz_q;
  logic [snvs_pkg::SumW-1:0]         sum2;
  logic [snvs_pkg::HalfSumW-1:0]     q2_q;
  logic [snvs_pkg::Prod3W-1:0]       prod3;
  snvs_pkg::sample_t                 avg3_q;
  logic signed [PairW-1:0]           delta4;
  logic signed [snvs_pkg::WeightW:0] wt_s;
  logic signed [snvs_pkg::ProdW-1:0] prod4;
  logic signed [snvs_pkg::ProdW-1:0] prod4_q;
  logic signed [snvs_pkg::ProdW-1:0] rnd5;
  logic signed [AdjW-1:0]            adj5;
  logic signed [AdjW:0]              mix5;
  snvs_pkg::sample_t                 voxel5_q;

  assign en5     = !v5_q || m_ready_i;
  assign en4     = !v4_q || en5;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;

  // missing neighbors at the volume edge take the center sample
  assign nxm = ctrl_i.xm ? taps_i.xm : taps_i.ctr;
  assign nxp = ctrl_i.xp ? taps_i.xp : taps_i.ctr;
  assign nym = ctrl_i.ym ? taps_i.ym : taps_i.ctr;
  assign nyp = ctrl_i.yp ? taps_i.yp : taps_i.ctr;
  assign nzm = ctrl_i.zm ? taps_i.zm : taps_i.ctr;
  assign nzp = ctrl_i.zp ? taps_i.zp : taps_i.ctr;

  // (sum + 3) / 6 == ((sum + 3) >> 1) / 3
  assign sum2  = snvs_pkg::SumW'(sx_q) + snvs_pkg::SumW'(sy_q) + snvs_pkg::SumW'(sz_q)
               + snvs_pkg::SumW'(3);
  assign prod3 = snvs_pkg::Prod3W'(q2_q) * snvs_pkg::Prod3W'(snvs_pkg::Recip3);

  // blend as ctr + w * (avg - ctr), rounded half up
  assign delta4 = $signed({1'b0, avg3_q}) - $signed({1'b0, c3_q});
  assign wt_s   = $signed({1'b0, weight_i});
  assign prod4  = wt_s * delta4;

  assign rnd5 = prod4_q + snvs_pkg::ProdW'(snvs_pkg::RoundHalf);
  assign adj5 = $signed(rnd5[snvs_pkg::ProdW-1:snvs_pkg::WeightFrac]);
  assign mix5 = $signed({1'b0, c4_q}) + adj5;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= ctrl_i.valid;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
      if (en5) begin
        v5_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      sx_q <= PairW'(nxm) + PairW'(nxp);
      sy_q <= PairW'(nym) + PairW'(nyp);
      sz_q <= PairW'(nzm) + PairW'(nzp);
      c1_q <= taps_i.ctr;
      l1_q <= ctrl_i.last;
    end
    if (en2) begin
      q2_q <= sum2[snvs_pkg::SumW-1:1];
      c2_q <= c1_q;
      l2_q <= l1_q;
    end
    if (en3) begin
      avg3_q <= prod3[snvs_pkg::Recip3Shift +: snvs_pkg::SampleW];
      c3_q   <= c2_q;
      l3_q   <= l2_q;
    end
    if (en4) begin
      prod4_q <= prod4;
      c4_q    <= c3_q;
      l4_q    <= l3_q;
    end
    if (en5) begin
      voxel5_q <= mix5[snvs_pkg::SampleW-1:0];
      l5_q     <= l4_q;
    end
  end

  assign m_valid_o = v5_q;
  assign m_voxel_o = voxel5_q;
  assign m_last_o  = l5_q;

endmodule

`default_nettype wire

FILE: design/six_neighbor_volume_smoother.sv
// Results trail pushed voxels by one plane; drain items emit the rest. Throughput: one item
// per cycle while the output is not stalled, bounded by the window delay RAMs (one read,
// one write each). Reset: stream counters clear, dimensions go to 64 and the weight to 1.0;
// window RAMs are not cleared. Input is held off after reset and after a dimension write.
`default_nettype none

module six_neighbor_volume_smoother (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [15:0]                   s_axis_tdata,   // [15:0] voxel_in
  input  wire logic                          s_axis_tuser,   // [0] command
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [15:0]                        m_axis_tdata,   // [15:0] voxel_out
  output logic                               m_axis_tlast,
  input  wire logic                          cfg_we_i,
  input  wire logic [snvs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [snvs_pkg::WeightW-1:0]  cfg_wdata_i
);

  logic [snvs_pkg::DimW-1:0]    width_q, height_q, depth_q;
  logic [snvs_pkg::WeightW-1:0] weight_q;
  logic                         restart;
  logic                         arith_ready;
  snvs_pkg::ctrl_t              ctrl;
  snvs_pkg::taps_t              taps;

  function automatic logic [snvs_pkg::DimW-1:0] clamp_dim(
    input logic [snvs_pkg::DimW-1:0] v,
    input logic [snvs_pkg::DimW-1:0] maxv
  );
    logic [snvs_pkg::DimW-1:0] r;
    if (v == '0) begin
      r = snvs_pkg::DimW'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign restart = cfg_we_i
                && (snvs_pkg::cfg_reg_e'(cfg_index_i) != snvs_pkg::RegWeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= snvs_pkg::DimW'(snvs_pkg::MaxWidth);
      height_q <= snvs_pkg::DimW'(snvs_pkg::MaxHeight);
      depth_q  <= snvs_pkg::DimW'(snvs_pkg::MaxDepth);
      weight_q <= snvs_pkg::WeightW'(snvs_pkg::WeightOne);
    end else if (cfg_we_i) begin
      unique case (snvs_pkg::cfg_reg_e'(cfg_index_i))
        snvs_pkg::RegWidth: begin
          width_q <= clamp_dim(cfg_wdata_i[snvs_pkg::DimW-1:0],
                               snvs_pkg::DimW'(snvs_pkg::MaxWidth));
        end
        snvs_pkg::RegHeight: begin
          height_q <= clamp_dim(cfg_wdata_i[snvs_pkg::DimW-1:0],
                                snvs_pkg::DimW'(snvs_pkg::MaxHeight));
        end
        snvs_pkg::RegDepth: begin
          depth_q <= clamp_dim(cfg_wdata_i[snvs_pkg::DimW-1:0],
                               snvs_pkg::DimW'(snvs_pkg::MaxDepth));
        end
        snvs_pkg::RegWeight: begin
          // saturate above 1.0
          weight_q <= (cfg_wdata_i > snvs_pkg::WeightW'(snvs_pkg::WeightOne))
                    ? snvs_pkg::WeightW'(snvs_pkg::WeightOne) : cfg_wdata_i;
        end
        default: begin
          weight_q <= weight_q;
        end
      endcase
    end
  end

  snvs_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (restart),
    .width_i      (width_q),
    .height_i     (height_q),
    .depth_i      (depth_q),
    .s_valid_i    (s_axis_tvalid),
    .s_cmd_i      (s_axis_tuser),
    .s_voxel_i    (s_axis_tdata),
    .s_ready_o    (s_axis_tready),
    .next_ready_i (arith_ready),
    .ctrl_o       (ctrl),
    .taps_o       (taps)
  );

  snvs_arith u_arith (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .weight_i  (weight_q),
    .ctrl_i    (ctrl),
    .taps_i    (taps),
    .ready_o   (arith_ready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_voxel_o (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import snvs_pkg::*;

  localparam int StoreDepth   = 2 * MaxWidth * MaxHeight + 1;
  localparam int SettleCycles = 12;

  typedef struct {
    logic [SampleW-1:0] voxel;
    logic               last;
  } smoothed_voxel_t;

  class smoothing_scoreboard;
    logic [DimW-1:0]    width_reg  = DimW'(MaxWidth);
    logic [DimW-1:0]    height_reg = DimW'(MaxHeight);
    logic [DimW-1:0]    depth_reg  = DimW'(MaxDepth);
    logic [WeightW-1:0] weight_reg = WeightW'(WeightOne);
    logic [SampleW-1:0] window_mem [StoreDepth];
    int unsigned        in_count = 0;
    int unsigned        out_x = 0, out_y = 0, out_z = 0;
    smoothed_voxel_t    pending_voxels [$];
    int unsigned        voxels_checked = 0;
    int unsigned        mismatches = 0;

    function int unsigned dim_of(logic [DimW-1:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function void restart();
      in_count = 0;
      out_x = 0;
      out_y = 0;
      out_z = 0;
    endfunction

    function void apply_register(cfg_reg_e idx, logic [WeightW-1:0] value);
      case (idx)
        RegWidth: begin
          width_reg = value[DimW-1:0];
          restart();
        end
        RegHeight: begin
          height_reg = value[DimW-1:0];
          restart();
        end
        RegDepth: begin
          depth_reg = value[DimW-1:0];
          restart();
        end
        RegWeight: weight_reg = value;
        default: ;
      endcase
    endfunction

    function logic [SampleW-1:0] tap(int unsigned pos);
      return window_mem[pos % StoreDepth];
    endfunction

    // Average the six face neighbors of the next output voxel and blend with the center
    function void smooth_next(int unsigned w, int unsigned h, int unsigned d);
      int unsigned       plane, p;
      longint unsigned   ctr, nsum, avg, wt, mixed;
      smoothed_voxel_t   res;
      plane = w * h;
      p = out_x + w * (out_y + h * out_z);
      ctr = tap(p);
      nsum = (out_x > 0) ? tap(p - 1) : ctr;
      nsum += (out_x + 1 < w) ? tap(p + 1) : ctr;
      nsum += (out_y > 0) ? tap(p - w) : ctr;
      nsum += (out_y + 1 < h) ? tap(p + w) : ctr;
      nsum += (out_z > 0) ? tap(p - plane) : ctr;
      nsum += (out_z + 1 < d) ? tap(p + plane) : ctr;
      avg = (nsum + 3) / 6;
      wt = (weight_reg > WeightOne) ? WeightOne : weight_reg;
      mixed = (wt * avg + (WeightOne - wt) * ctr + RoundHalf) >> WeightFrac;
      res.voxel = SampleW'(mixed);
      res.last  = (p + 1 == plane * d);
      pending_voxels.push_back(res);
      if (res.last) begin
        restart();
      end else if (out_x + 1 < w) begin
        out_x++;
      end else begin
        out_x = 0;
        if (out_y + 1 < h) begin
          out_y++;
        end else begin
          out_y = 0;
          out_z++;
        end
      end
    endfunction

    function void note_item(logic cmd, logic [SampleW-1:0] vox);
      int unsigned w, h, d, plane, total;
      w = dim_of(width_reg, MaxWidth);
      h = dim_of(height_reg, MaxHeight);
      d = dim_of(depth_reg, MaxDepth);
      plane = w * h;
      total = plane * d;
      if (cmd == CmdPush && in_count < total) begin
        window_mem[in_count % StoreDepth] = vox;
        in_count++;
        if ((in_count > plane && in_count < total) || (in_count == total && total > plane))
          smooth_next(w, h, d);
      end else if (in_count >= total) begin
        // drain, or a push past the end that acts as one
        smooth_next(w, h, d);
      end
    endfunction

    function void fault(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function void check_voxel(logic [SampleW-1:0] vox, logic last);
      smoothed_voxel_t want;
      voxels_checked++;
      if (pending_voxels.size() == 0) begin
        fault($sformatf("unexpected voxel %h last %b", vox, last));
        return;
      end
      want = pending_voxels.pop_front();
      if (vox !== want.voxel || last !== want.last)
        fault($sformatf("voxel %0d: expected %h last %b, got %h last %b",
                        voxels_checked, want.voxel, want.last, vox, last));
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [SampleW-1:0]   s_axis_tdata = '0;   // [15:0] voxel_in
  logic                 s_axis_tuser = 1'b0; // [0] command
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [SampleW-1:0]   m_axis_tdata;        // [15:0] voxel_out
  logic                 m_axis_tlast;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [WeightW-1:0]   cfg_wdata_i = '0;

  smoothing_scoreboard scoreboard = new();
  int unsigned src_stall_pct  = 30;
  int unsigned sink_stall_pct = 76;
  int unsigned items_streamed = 0;
  int unsigned volumes_streamed = 0;

  six_neighbor_volume_smoother u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      scoreboard.note_item(s_axis_tuser, s_axis_tdata);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      scoreboard.check_voxel(m_axis_tdata, m_axis_tlast);
  end

  task automatic send_item(input logic cmd, input logic [SampleW-1:0] vox);
    @(negedge clk_i);
    while ($urandom_range(99) < src_stall_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= vox;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid, wait for every expected voxel, then let the pipeline settle
  task automatic quiesce();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (scoreboard.pending_voxels.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_register(input cfg_reg_e idx, input logic [WeightW-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    scoreboard.apply_register(idx, value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Dimension word, sometimes with junk above the 7 register bits
  function automatic logic [WeightW-1:0] dim_word(input logic [DimW-1:0] dim);
    logic [WeightW-1:0] word;
    word = ($urandom_range(3) == 0) ? WeightW'($urandom()) : '0;
    word[DimW-1:0] = dim;
    return word;
  endfunction

  task automatic configure(input logic [DimW-1:0] dim_w, input logic [DimW-1:0] dim_h,
                           input logic [DimW-1:0] dim_d, input logic [WeightW-1:0] weight);
    quiesce();
    write_register(RegWidth, dim_word(dim_w));
    write_register(RegHeight, dim_word(dim_h));
    write_register(RegDepth, dim_word(dim_d));
    write_register(RegWeight, weight);
  endtask

  function automatic logic [SampleW-1:0] pick_voxel();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return SampleW'($urandom_range(7));
      3: return {SampleW{1'b1}} - SampleW'($urandom_range(7));
      default: return SampleW'($urandom());
    endcase
  endfunction

  function automatic logic [WeightW-1:0] pick_weight();
    case ($urandom_range(5))
      0: return '0;
      1: return WeightW'(WeightOne);
      2: return '1;
      3: return WeightW'($urandom_range(WeightOne + 1, 2 * WeightOne - 1));
      default: return WeightW'($urandom_range(WeightOne));
    endcase
  endfunction

  // mode 2: one long axis, saturating past the maximum; mode 1: thin; mode 0: small
  function automatic logic [DimW-1:0] pick_dim(input int unsigned mode);
    if (mode == 2) return DimW'($urandom_range(60, 127));
    if (mode == 1) return DimW'($urandom_range(2));
    if ($urandom_range(11) == 0) return '0;
    return DimW'($urandom_range(1, 4));
  endfunction

  // Stream one volume and drain it; abort_after > 0 stops early to test a restart
  task automatic smooth_volume(input logic [DimW-1:0] dim_w, input logic [DimW-1:0] dim_h,
                               input logic [DimW-1:0] dim_d, input logic [WeightW-1:0] weight,
                               input int unsigned noise_pct, input int unsigned abort_after);
    int unsigned plane, voxels, i;
    bit          reweight;
    configure(dim_w, dim_h, dim_d, weight);
    plane  = scoreboard.dim_of(dim_w, MaxWidth) * scoreboard.dim_of(dim_h, MaxHeight);
    voxels = plane * scoreboard.dim_of(dim_d, MaxDepth);
    reweight = ($urandom_range(7) == 0);
    volumes_streamed++;
    for (i = 0; i < voxels + plane; i++) begin
      if (i < voxels) begin
        // stray drains before the volume is complete are ignored
        if ($urandom_range(99) < noise_pct) send_item(CmdDrain, SampleW'($urandom()));
        send_item(CmdPush, pick_voxel());
      end else if ($urandom_range(99) < noise_pct) begin
        send_item(CmdPush, pick_voxel());
      end else begin
        send_item(CmdDrain, SampleW'($urandom()));
      end
      items_streamed++;
      if (i + 1 == abort_after) return;
      if (reweight && i + 1 == voxels / 2) begin
        quiesce();
        write_register(RegWeight, pick_weight());
      end
    end
  endtask

  task automatic random_volumes(input int unsigned target);
    int unsigned goal, long_axis, abort_after;
    logic [DimW-1:0] dw, dh, dd;
    goal = items_streamed + target;
    while (items_streamed < goal) begin
      long_axis = $urandom_range(9);
      dw = pick_dim(long_axis == 0 ? 2 : (long_axis < 3 ? 1 : 0));
      dh = pick_dim(long_axis == 1 ? 2 : (long_axis < 3 ? 1 : 0));
      dd = pick_dim(long_axis == 2 ? 2 : (long_axis < 3 ? 1 : 0));
      abort_after = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : 0;
      smooth_volume(dw, dh, dd, pick_weight(), ($urandom_range(2) == 0) ? 15 : 0, abort_after);
    end
  endtask

  initial begin
    int unsigned i;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Zero dimensions act as one; a push past the end drains; drains before the end do nothing
    configure('0, '0, '0, WeightW'(WeightOne));
    send_item(CmdDrain, '1);
    send_item(CmdPush, '1);
    send_item(CmdPush, 16'h1234);
    send_item(CmdDrain, '0);

    // Zero weight passes the center through
    configure(7'd2, 7'd2, 7'd2, '0);
    for (i = 0; i < 8; i++) send_item(CmdPush, i[0] ? '1 : '0);
    repeat (4) send_item(CmdDrain, '0);

    // Over-range weight saturates to the plain average
    configure(7'd3, 7'd1, 7'd2, '1);
    for (i = 0; i < 6; i++) send_item(CmdPush, i[0] ? 16'h0001 : 16'hFFFF);
    repeat (3) send_item(CmdPush, '1);
    items_streamed += 25;

    random_volumes(300);

    src_stall_pct  = 76;
    sink_stall_pct = 30;
    random_volumes(300);

    src_stall_pct  = 0;
    sink_stall_pct = 0;
    // Widest line once, to walk the full line delay
    smooth_volume(7'd64, 7'd4, 7'd2, pick_weight(), 0, 0);
    random_volumes(300);

    quiesce();
    $display("Streamed %0d items over %0d volumes, %0d smoothed voxels checked",
             items_streamed, volumes_streamed, scoreboard.voxels_checked);
    $display("Mismatches: %0d, voxels still expected: %0d",
             scoreboard.mismatches, scoreboard.pending_voxels.size());
    if (scoreboard.mismatches == 0 && scoreboard.pending_voxels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
design/snvs_pkg.sv
design/snvs_ram.sv
design/snvs_window.sv
design/snvs_arith.sv
design/six_neighbor_volume_smoother.sv
verif/tb_top.sv
